>>> hdl/gtd_pkg.sv
`timescale 1ns / 1ps

package gtd_pkg;

	localparam int SAMPLE_WIDTH        = 16;
	localparam int STATE_WIDTH         = 48;
	localparam int COEFF_FRACTION_BITS = 14;
	localparam int COEFF_WIDTH         = 16;
	localparam int MAG_WIDTH           = 64;

	// APB map: one 32-bit register per word
	localparam int APB_DATA_WIDTH = 32;
	localparam int APB_ADDR_WIDTH = 3;
	localparam logic [APB_ADDR_WIDTH-3:0] REG_TONE_COEFF = '0;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           block_end;
	} sample_item_t;

	typedef struct packed {
		logic [MAG_WIDTH-1:0] magnitude_squared;
		logic                 saturated;
	} result_item_t;

	typedef struct packed {
		logic start;
		logic short_len;
	} mul_cmd_t;

	typedef struct packed {
		logic done;
	} mul_stat_t;

endpackage

>>> hdl/gtd_serial_mul.sv
`timescale 1ns / 1ps

// Signed shift-add multiplier, one multiplier bit per cycle, LSB first.
// The partial product shifts right through hi_q/lo_q; the sign bit of the
// multiplier subtracts on the last step.
module gtd_serial_mul #(
	parameter int MW = gtd_pkg::STATE_WIDTH + gtd_pkg::COEFF_WIDTH,
	parameter int BW = gtd_pkg::STATE_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gtd_pkg::mul_cmd_t       cmd,
	input  logic signed [MW-1:0]    mcand,
	input  logic        [BW-1:0]    mplier,
	output gtd_pkg::mul_stat_t      stat,
	output logic signed [MW+BW-1:0] product
);

	localparam int CW    = gtd_pkg::COEFF_WIDTH;
	localparam int CNT_W = $clog2(BW);

	logic             busy_q;
	logic             done_q;
	logic             short_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MW-1:0]    a_q;
	logic [MW:0]      hi_q;
	logic [BW-1:0]    lo_q;

	logic [MW:0] a_ext;
	logic [MW:0] addend;
	logic [MW:0] sum;

	always_comb begin
		a_ext = {a_q[MW-1], a_q};
		if (!lo_q[0]) begin
			addend = '0;
		end else if (cnt_q == '0) begin
			addend = -a_ext;
		end else begin
			addend = a_ext;
		end
		sum = hi_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q     <= mcand;
			hi_q    <= '0;
			lo_q    <= mplier;
			short_q <= cmd.short_len;
			cnt_q   <= cmd.short_len ? CNT_W'(CW - 1) : CNT_W'(BW - 1);
		end else if (busy_q) begin
			hi_q  <= {sum[MW], sum[MW:1]};
			lo_q  <= {sum[0], lo_q[BW-1:1]};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign stat.done = done_q;

	// short run: only the top CW bits of lo_q hold product bits
	assign product = short_q ?
		{{(BW-CW-1){hi_q[MW]}}, hi_q, lo_q[BW-1 -: CW]} :
		{hi_q[MW-1:0], lo_q};

endmodule

>>> hdl/goertzel_tone_detector.sv
`timescale 1ns / 1ps

// Goertzel tone detector.
// Sample channel: sample_valid/sample_ready carry one signed sample per item,
// with block_end marking the last sample of a block. Result channel:
// result_valid/result_ready carry the squared magnitude and a saturation flag,
// one item per finished block. The coefficient (2*cos, signed Q2.14 at the
// default fraction) is written over the APB port at address 0; the user must
// write it only while idle, since the block itself does not enforce this.
// Each sample runs c*s1 through a bit-serial multiplier, one coefficient bit a
// cycle, and no new sample is accepted until that recurrence is done.
// A block-end sample then runs s1*s1, s2*s2, c*s1 and (c*s1)*s2 on the same
// multiplier before the result is loaded into the output register.
// A result waiting in the output register does not stop ordinary samples; only
// a second block end waits until the receiver has taken the first result.
// Reset clears the coefficient, both delay words and the saturation flag, and
// empties the output register.
module goertzel_tone_detector #(
	parameter int STATE_WIDTH         = gtd_pkg::STATE_WIDTH,
	parameter int COEFF_FRACTION_BITS = gtd_pkg::COEFF_FRACTION_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  gtd_pkg::sample_item_t                sample_item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output gtd_pkg::result_item_t                result_item,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gtd_pkg::APB_ADDR_WIDTH-1:0]   paddr,
	input  logic [gtd_pkg::APB_DATA_WIDTH-1:0]   pwdata,
	output logic [gtd_pkg::APB_DATA_WIDTH-1:0]   prdata,
	output logic                                 pready
);

	localparam int SW  = STATE_WIDTH;
	localparam int CW  = gtd_pkg::COEFF_WIDTH;
	localparam int XW  = gtd_pkg::SAMPLE_WIDTH;
	localparam int MW  = SW + CW;
	localparam int BW  = SW;
	localparam int W   = MW + BW;
	localparam int MAG = gtd_pkg::MAG_WIDTH;
	localparam int AW  = gtd_pkg::APB_ADDR_WIDTH;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_MUL   = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		OP_REC,
		OP_SQ1,
		OP_SQ2,
		OP_CP,
		OP_CPS
	} op_t;

	state_t state_q;
	op_t    op_q;

	logic signed [CW-1:0] coeff_q;
	logic signed [SW-1:0] d1_q;
	logic signed [SW-1:0] d2_q;
	logic                 ovf_q;
	logic signed [XW-1:0] x_q;
	logic                 end_q;
	logic signed [MW-1:0] p_q;
	logic signed [W-1:0]  mag_q;
	logic                 res_valid_q;
	gtd_pkg::result_item_t res_q;

	gtd_pkg::mul_cmd_t  mul_cmd;
	gtd_pkg::mul_stat_t mul_stat;
	logic signed [MW-1:0] mul_mcand;
	logic        [BW-1:0] mul_mplier;
	logic signed [W-1:0]  mul_product;

	logic signed [MW-1:0]   rec_prod;
	logic signed [MW-1:0]   rec_shift;
	logic signed [MW+1:0]   rec_sum;
	logic [MW+2-SW:0]       rec_top;
	logic                   rec_fits;
	logic signed [SW-1:0]   rec_sat;
	logic signed [W-1:0]    cps_shift;
	logic                   mag_neg;
	logic                   mag_big;
	logic                   cfg_wr;
	logic                   res_load;

	// ---------------------------------------------------------------
	// APB register
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[AW-1:2] == gtd_pkg::REG_TONE_COEFF);
	assign prdata = (paddr[AW-1:2] == gtd_pkg::REG_TONE_COEFF) ?
		{{(gtd_pkg::APB_DATA_WIDTH-CW){1'b0}}, coeff_q} : '0;

	// ---------------------------------------------------------------
	// Multiplier operand selection
	// ---------------------------------------------------------------
	always_comb begin
		mul_cmd.start     = (state_q == ST_ISSUE);
		mul_cmd.short_len = 1'b0;
		mul_mcand         = {{CW{d1_q[SW-1]}}, d1_q};
		mul_mplier        = d1_q;
		case (op_q)
			OP_REC, OP_CP: begin
				mul_cmd.short_len = 1'b1;
				mul_mplier        = {{(BW-CW){1'b0}}, coeff_q};
			end
			OP_SQ1: begin
				mul_mplier = d1_q;
			end
			OP_SQ2: begin
				mul_mcand  = {{CW{d2_q[SW-1]}}, d2_q};
				mul_mplier = d2_q;
			end
			OP_CPS: begin
				mul_mcand  = p_q;
				mul_mplier = d2_q;
			end
			default: begin
				mul_mplier = d1_q;
			end
		endcase
	end

	gtd_serial_mul #(
		.MW(MW),
		.BW(BW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.mcand  (mul_mcand),
		.mplier (mul_mplier),
		.stat   (mul_stat),
		.product(mul_product)
	);

	// ---------------------------------------------------------------
	// Recurrence tail, saturation and magnitude clamp
	// ---------------------------------------------------------------
	always_comb begin
		rec_prod  = mul_product[MW-1:0];
		rec_shift = rec_prod >>> COEFF_FRACTION_BITS;
		rec_sum   = {{2{rec_shift[MW-1]}}, rec_shift}
			- {{(MW+2-SW){d2_q[SW-1]}}, d2_q}
			+ {{(MW+2-XW){x_q[XW-1]}}, x_q};
		rec_top   = rec_sum[MW+1:SW-1];
		rec_fits  = (&rec_top) || !(|rec_top);
		if (rec_fits) begin
			rec_sat = rec_sum[SW-1:0];
		end else if (rec_sum[MW+1]) begin
			rec_sat = {1'b1, {(SW-1){1'b0}}};
		end else begin
			rec_sat = {1'b0, {(SW-1){1'b1}}};
		end
		cps_shift = mul_product >>> COEFF_FRACTION_BITS;
		mag_neg   = mag_q[W-1];
		mag_big   = |mag_q[W-2:MAG];
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign res_load     = (state_q == ST_EMIT) && (!res_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_REC;
			coeff_q     <= '0;
			d1_q        <= '0;
			d2_q        <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				coeff_q <= pwdata[CW-1:0];
			end
			if (res_valid_q && result_ready && !res_load) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						op_q    <= OP_REC;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_stat.done) begin
						case (op_q)
							OP_REC: begin
								d2_q  <= d1_q;
								d1_q  <= rec_sat;
								ovf_q <= ovf_q || !rec_fits;
								if (end_q) begin
									op_q    <= OP_SQ1;
									state_q <= ST_ISSUE;
								end else begin
									state_q <= ST_IDLE;
								end
							end
							OP_SQ1: begin
								op_q    <= OP_SQ2;
								state_q <= ST_ISSUE;
							end
							OP_SQ2: begin
								op_q    <= OP_CP;
								state_q <= ST_ISSUE;
							end
							OP_CP: begin
								op_q    <= OP_CPS;
								state_q <= ST_ISSUE;
							end
							OP_CPS: state_q <= ST_EMIT;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_EMIT: begin
					if (res_load) begin
						res_valid_q <= 1'b1;
						d1_q        <= '0;
						d2_q        <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			x_q   <= sample_item.sample;
			end_q <= sample_item.block_end;
		end
		if (state_q == ST_MUL && mul_stat.done) begin
			case (op_q)
				OP_SQ1: mag_q <= mul_product;
				OP_SQ2: mag_q <= mag_q + mul_product;
				OP_CP:  p_q   <= mul_product[MW-1:0];
				OP_CPS: mag_q <= mag_q - cps_shift;
				default: p_q  <= p_q;
			endcase
		end
		if (res_load) begin
			if (mag_neg) begin
				res_q.magnitude_squared <= '0;
			end else if (mag_big) begin
				res_q.magnitude_squared <= '1;
			end else begin
				res_q.magnitude_squared <= mag_q[MAG-1:0];
			end
			res_q.saturated <= ovf_q || mag_neg || mag_big;
		end
	end

	assign result_valid = res_valid_q;
	assign result_item  = res_q;

endmodule

>>> hdl/gtd_checker.sv
`timescale 1ns / 1ps

module gtd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  sample_valid,
	input logic                  sample_ready,
	input logic                  result_valid,
	input logic                  result_ready,
	input gtd_pkg::result_item_t result_item
);

	// a stalled result item holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_item))
		else $error("result item changed while stalled");

	// one sample at a time: the multiplier keeps the block busy after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready ##1 !sample_ready)
		else $error("sample accepted while recurrence in progress");

	// a new result is only loaded while the sample side is closed
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_ready))
		else $error("result appeared without a finished block");

endmodule

bind goertzel_tone_detector gtd_checker u_gtd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_valid(sample_valid),
	.sample_ready(sample_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result_item (result_item)
);

>>> sim/gtd_checker.sv
`timescale 1ns / 1ps

module gtd_tb_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	input  logic                                 sample_ready,
	input  gtd_pkg::sample_item_t                sample_item,
	input  logic                                 result_valid,
	input  logic                                 result_ready,
	input  gtd_pkg::result_item_t                result_item,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gtd_pkg::APB_ADDR_WIDTH-1:0]   paddr,
	input  logic [gtd_pkg::APB_DATA_WIDTH-1:0]   pwdata,
	input  logic [gtd_pkg::APB_DATA_WIDTH-1:0]   prdata,
	input  logic                                 pready,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   checked
);

	localparam int WIDE        = 160;
	localparam int MAX_REPORTS = 10;
	localparam int SW          = gtd_pkg::STATE_WIDTH;
	localparam int CW          = gtd_pkg::COEFF_WIDTH;
	localparam int FB          = gtd_pkg::COEFF_FRACTION_BITS;
	localparam int MAGW        = gtd_pkg::MAG_WIDTH;
	localparam int AW          = gtd_pkg::APB_ADDR_WIDTH;

	localparam logic signed [SW-1:0] STATE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] STATE_MIN = {1'b1, {(SW-1){1'b0}}};

	typedef logic signed [WIDE-1:0] wide_t;

	logic signed [CW-1:0]  coef;
	logic signed [SW-1:0]  dly1;
	logic signed [SW-1:0]  dly2;
	bit                    ovf;
	gtd_pkg::result_item_t pending_magnitudes[$];
	int                    errs;
	int                    n_checked;

	task automatic flag_error(input string msg);
		errs++;
		if (errs <= MAX_REPORTS)
			$display("%0t ns: mismatch: %s", $realtime, msg);
	endtask

	// advance the recurrence by one sample; on block end queue the magnitude and clear
	task automatic fold_sample(input gtd_pkg::sample_item_t it);
		wide_t                 c;
		wide_t                 x;
		wide_t                 s1;
		wide_t                 s2;
		wide_t                 s;
		wide_t                 m;
		gtd_pkg::result_item_t want;
		bit                    clipped;
		c = coef;
		x = $signed(it.sample);
		s1 = dly1;
		s2 = dly2;
		s = ((c * s1) >>> FB) - s2 + x;
		dly2 = dly1;
		if (s[WIDE-1:SW-1] == '0 || s[WIDE-1:SW-1] == '1) begin
			dly1 = s[SW-1:0];
		end else begin
			ovf = 1'b1;
			dly1 = s[WIDE-1] ? STATE_MIN : STATE_MAX;
		end
		if (it.block_end) begin
			s1 = dly1;
			s2 = dly2;
			m = s1 * s1 + s2 * s2 - ((c * s1 * s2) >>> FB);
			clipped = 1'b0;
			if (m < 0) begin
				want.magnitude_squared = '0;
				clipped = 1'b1;
			end else if (m[WIDE-1:MAGW] != '0) begin
				want.magnitude_squared = '1;
				clipped = 1'b1;
			end else begin
				want.magnitude_squared = m[MAGW-1:0];
			end
			want.saturated = ovf | clipped;
			pending_magnitudes.push_back(want);
			dly1 = '0;
			dly2 = '0;
			ovf = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gtd_pkg::result_item_t want;
		if (!arst_n) begin
			coef = '0;
			dly1 = '0;
			dly2 = '0;
			ovf = 1'b0;
			pending_magnitudes.delete();
			errs = 0;
			n_checked = 0;
		end else begin
			if (psel && penable && pready && paddr[AW-1:2] == gtd_pkg::REG_TONE_COEFF) begin
				if (pwrite)
					coef = pwdata[CW-1:0];
				else if (prdata[CW-1:0] !== coef)
					flag_error($sformatf("coefficient read expected %h got %h",
						coef, prdata[CW-1:0]));
			end
			if (result_valid && result_ready) begin
				if (pending_magnitudes.size() == 0) begin
					flag_error($sformatf("result with no block pending: mag %h sat %b",
						result_item.magnitude_squared, result_item.saturated));
				end else begin
					want = pending_magnitudes.pop_front();
					n_checked++;
					if (result_item.magnitude_squared !== want.magnitude_squared)
						flag_error($sformatf("magnitude expected %h got %h",
							want.magnitude_squared, result_item.magnitude_squared));
					if (result_item.saturated !== want.saturated)
						flag_error($sformatf("saturated expected %b got %b",
							want.saturated, result_item.saturated));
				end
			end
			if (sample_valid && sample_ready)
				fold_sample(sample_item);
		end
		fail_count <= errs;
		pending <= pending_magnitudes.size();
		checked <= n_checked;
	end

endmodule

>>> sim/tb_goertzel_tone_detector.sv
`timescale 1ns / 1ps

module tb_goertzel_tone_detector;

	localparam int SEGMENTS      = 9;
	localparam int SEG_ITEMS     = 150;
	localparam int DRAIN_CYCLES  = 250;
	localparam int QUIET_LIMIT   = 4000;
	localparam int STALL_AT      = 10;
	localparam int STALL_CYCLES  = 600;

	localparam int XW = gtd_pkg::SAMPLE_WIDTH;
	localparam int CW = gtd_pkg::COEFF_WIDTH;
	localparam int AW = gtd_pkg::APB_ADDR_WIDTH;
	localparam int DW = gtd_pkg::APB_DATA_WIDTH;

	localparam logic [AW-1:0] COEFF_ADDR = {gtd_pkg::REG_TONE_COEFF, 2'b00};
	localparam logic [AW-1:0] SPARE_ADDR = {~gtd_pkg::REG_TONE_COEFF, 2'b00};

	localparam logic signed [XW-1:0] S_MAX = 16'sh7fff;
	localparam logic signed [XW-1:0] S_MIN = 16'sh8000;

	typedef enum int {
		PAT_RANDOM,
		PAT_EXTREME,
		PAT_SMALL,
		PAT_STEADY,
		PAT_ALTERNATE,
		PAT_NOISE
	} pattern_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   sample_valid = 1'b0;
	logic                   sample_ready;
	gtd_pkg::sample_item_t  sample_item  = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	gtd_pkg::result_item_t  result_item;
	logic                   psel         = 1'b0;
	logic                   penable      = 1'b0;
	logic                   pwrite       = 1'b0;
	logic [AW-1:0]          paddr        = '0;
	logic [DW-1:0]          pwdata       = '0;
	logic [DW-1:0]          prdata;
	logic                   pready;

	int fail_count;
	int pending;
	int checked;

	int send_idle_pct = 11;
	int recv_idle_pct = 47;
	int samples_sent  = 0;
	int coef_writes   = 0;

	int results_taken = 0;
	int stall_left    = 0;
	bit stall_done    = 1'b0;

	goertzel_tone_detector uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_item  (sample_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	gtd_tb_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_item  (sample_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked)
	);

	always #6 clk = ~clk;

	// receiver: random idling, plus one long hold-off once a few results have come
	always @(posedge clk) begin
		if (result_valid && result_ready)
			results_taken <= results_taken + 1;
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!stall_done && results_taken == STALL_AT) begin
			stall_done <= 1'b1;
			stall_left <= STALL_CYCLES;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && sample_ready) || (result_valid && result_ready)
					|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles", quiet);
		$display("goertzel_tone_detector regression: fail");
		$finish;
	end

	task automatic send_sample(input logic signed [XW-1:0] smp, input logic be);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item <= '{sample: smp, block_end: be};
		do @(posedge clk); while (!sample_ready);
		samples_sent++;
	endtask

	// setup, access, then idle so that accesses never overlap
	task automatic apb_access(input logic wr, input logic [AW-1:0] addr,
			input logic [DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// junk in the upper half checks that only the low 16 bits are kept
	task automatic set_coefficient(input logic signed [CW-1:0] val);
		logic [DW-1:0] word;
		word = $urandom;
		word[CW-1:0] = val;
		apb_access(1'b1, COEFF_ADDR, word);
		apb_access(1'b0, COEFF_ADDR, '0);
		coef_writes++;
	endtask

	// drop valid, wait for every outstanding magnitude, then let the block go quiet
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] coef_for_segment(input int seg);
		case (seg)
			0: return 16'sd16384;
			2: return -16'sd16384;
			4: return '0;
			5: return 16'sh7fff;
			7: return 16'sh8000;
			8: return 16'sd23170;
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic logic signed [XW-1:0] draw_sample(input pattern_t pat,
			input int idx);
		case (pat)
			PAT_EXTREME: begin
				case ($urandom_range(3))
					0: return S_MAX;
					1: return S_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			PAT_SMALL: return XW'($urandom_range(16) - 8);
			PAT_STEADY: return S_MAX;
			PAT_ALTERNATE: return idx[0] ? S_MIN : S_MAX;
			default: return XW'($urandom);
		endcase
	endfunction

	task automatic run_segment();
		int       left;
		int       len;
		int       r;
		pattern_t pat;
		logic     be;
		left = SEG_ITEMS;
		while (left > 0) begin
			r = $urandom_range(99);
			if (r < 10)
				len = 1;
			else if (r < 75)
				len = $urandom_range(12, 2);
			else if (r < 95)
				len = $urandom_range(64, 13);
			else
				len = $urandom_range(256, 65);
			if (len > left)
				len = left;
			pat = pattern_t'($urandom_range(5));
			for (int i = 0; i < len; i++) begin
				be = (i == len - 1);
				if (pat == PAT_NOISE && $urandom_range(7) == 0)
					be = 1'b1;
				send_sample(draw_sample(pat, i), be);
			end
			left -= len;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coefficient still at its reset value: single-sample blocks and extremes
		send_sample(S_MAX, 1'b1);
		send_sample(S_MIN, 1'b1);
		send_sample('0, 1'b1);
		send_sample('1, 1'b0);
		send_sample(16'sd1, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b1);
		settle();

		// most negative coefficient with an alternating full-scale drive
		set_coefficient(16'sh8000);
		for (int i = 0; i < 8; i++)
			send_sample(i[0] ? S_MIN : S_MAX, i == 7);
		settle();

		// most positive coefficient with a steady full-scale drive
		set_coefficient(16'sh7fff);
		for (int i = 0; i < 6; i++)
			send_sample(S_MAX, i == 5);
		settle();

		// a write to an unmapped address must leave the coefficient alone
		apb_access(1'b1, SPARE_ADDR, $urandom);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample('0, 1'b1);
		settle();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 3) begin
				send_idle_pct = 11;
				recv_idle_pct = 47;
			end else if (seg < 6) begin
				send_idle_pct = 47;
				recv_idle_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_coefficient(coef_for_segment(seg));
			run_segment();
			settle();
		end

		$display("covered %0d samples and %0d block results over %0d coefficient settings,",
			samples_sent, checked, coef_writes + 1);
		$display("three idling mixes and one long result hold-off; %0d mismatches",
			fail_count);
		if (fail_count == 0)
			$display("goertzel_tone_detector regression: pass");
		else
			$display("goertzel_tone_detector regression: fail");
		$finish;
	end

endmodule

>>> files.f
hdl/gtd_pkg.sv
hdl/gtd_serial_mul.sv
hdl/goertzel_tone_detector.sv
hdl/gtd_checker.sv
sim/gtd_checker.sv
sim/tb_goertzel_tone_detector.sv
